@@ src/svm_pkg.sv @@
// Shared types and constants of the sample voice mixer.
package svm_pkg;

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int IDX_W     = 3;
  localparam int SND_W     = 2;
  localparam int GAIN_W    = 9;
  localparam int GAIN_FRAC = 8;
  localparam int ADDR_IN_W = 14;
  localparam int SAMPLE_W  = 16;
  localparam int LEN_W     = 15;
  localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;

  // Configuration registers: sound lengths 0..3
  localparam int CFG_COUNT = 4;
  localparam int CFG_IDX_W = 2;

  // Item opcodes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_TRIG = 2'd1,
    OP_TICK = 2'd2
  } op_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Input beat, first field in the highest bits
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [ADDR_IN_W-1:0]       sample_address;
    logic [GAIN_W-1:0]          right_volume;
    logic [GAIN_W-1:0]          left_volume;
    logic [IDX_W-1:0]           sound_index;
    logic [IDX_W-1:0]           voice_index;
    logic [OP_W-1:0]            op;
  } in_beat_t;

  // Output beat, first field in the highest bits
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] right_out;
    logic signed [SAMPLE_W-1:0] left_out;
  } out_beat_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_we;
    logic trig_we;
    logic acc_clr;
    logic issue;
    logic out_load;
  } ctrl_cmd_t;

endpackage

@@ src/svm_ctrl.sv @@
// Controller state machine: item decode, voice sequencing and output handshake.
module svm_ctrl #(
  parameter int VOICE_COUNT = 4,
  localparam int VI_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [svm_pkg::OP_W-1:0]    in_op_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output svm_pkg::ctrl_cmd_t          cmd_o,
  output logic [VI_W-1:0]             vidx_o
);

  localparam logic [VI_W-1:0] LAST_VOICE = VI_W'(VOICE_COUNT - 1);
  localparam logic [VI_W-1:0] LAST_DRAIN = VI_W'(1);

  svm_pkg::state_e state_q, state_d;
  logic [VI_W-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  // Next state and counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      svm_pkg::ST_IDLE: begin
        if (in_valid_i && in_op_i == svm_pkg::OP_TICK) begin
          state_d = svm_pkg::ST_MIX;
          cnt_d   = '0;
        end
      end
      svm_pkg::ST_MIX: begin
        if (cnt_q == LAST_VOICE) begin
          state_d = svm_pkg::ST_DRAIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + VI_W'(1);
        end
      end
      svm_pkg::ST_DRAIN: begin
        if (cnt_q == LAST_DRAIN) begin
          state_d = svm_pkg::ST_FINISH;
        end else begin
          cnt_d = cnt_q + VI_W'(1);
        end
      end
      svm_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = svm_pkg::ST_IDLE;
        end
      end
      default: state_d = svm_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    vidx_o     = cnt_q;
    case (state_q)
      svm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_op_i)
            svm_pkg::OP_LOAD: cmd_o.load_we = 1'b1;
            svm_pkg::OP_TRIG: cmd_o.trig_we = 1'b1;
            svm_pkg::OP_TICK: cmd_o.acc_clr = 1'b1;
            default:          cmd_o = '0;
          endcase
        end
      end
      svm_pkg::ST_MIX:    cmd_o.issue = 1'b1;
      svm_pkg::ST_DRAIN:  cmd_o = '0;
      svm_pkg::ST_FINISH: cmd_o.out_load = !out_valid_q || out_ready_i;
      default:            cmd_o = '0;
    endcase
  end

  // Output slot: fill on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svm_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/svm_datapath.sv @@
// Datapath: sample store, voice state, scaling multipliers and channel accumulators.
module svm_datapath #(
  parameter int VOICE_COUNT   = 4,
  parameter int SOUND_COUNT   = 4,
  parameter int SOUND_SAMPLES = 16384,
  localparam int VI_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  svm_pkg::ctrl_cmd_t                  cmd_i,
  input  logic [VI_W-1:0]                     vidx_i,
  input  logic [svm_pkg::IDX_W-1:0]           voice_index_i,
  input  logic [svm_pkg::IDX_W-1:0]           sound_index_i,
  input  logic [svm_pkg::GAIN_W-1:0]          left_volume_i,
  input  logic [svm_pkg::GAIN_W-1:0]          right_volume_i,
  input  logic [svm_pkg::ADDR_IN_W-1:0]       sample_address_i,
  input  logic signed [svm_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic                                cfg_we_i,
  input  logic [svm_pkg::CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [svm_pkg::LEN_W-1:0]           cfg_data_i,
  output logic signed [svm_pkg::SAMPLE_W-1:0] left_out_o,
  output logic signed [svm_pkg::SAMPLE_W-1:0] right_out_o
);

  localparam int STORE_DEPTH = SOUND_COUNT * SOUND_SAMPLES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam logic [16:0] SAMPLES_L = 17'(SOUND_SAMPLES);
  localparam logic [3:0]  SOUNDS_L  = 4'(SOUND_COUNT);
  localparam logic [4:0]  VOICES_L  = 5'(VOICE_COUNT);
  localparam int LEN_W  = svm_pkg::LEN_W;
  localparam int GAIN_W = svm_pkg::GAIN_W;
  localparam int SMP_W  = svm_pkg::SAMPLE_W;
  localparam int PROD_W = svm_pkg::PROD_W;
  localparam int FRAC   = svm_pkg::GAIN_FRAC;

  // Sound length registers
  logic [LEN_W-1:0] len_cfg_q [svm_pkg::CFG_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < svm_pkg::CFG_COUNT; i++) len_cfg_q[i] <= '0;
    end else if (cfg_we_i) begin
      len_cfg_q[cfg_addr_i] <= cfg_data_i;
    end
  end

  // Sample store: one write port for loads, one registered read port for mixing
  logic [SMP_W-1:0]  store_q [STORE_DEPTH];
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic              load_ok;
  logic signed [SMP_W-1:0] rdata_q;

  assign load_ok = cmd_i.load_we && ({1'b0, sound_index_i} < SOUNDS_L) &&
                   ({3'b0, sample_address_i} < SAMPLES_L);
  assign wr_addr = ADDR_W'(32'(sound_index_i[svm_pkg::SND_W-1:0]) * 32'(SOUND_SAMPLES) +
                           32'(sample_address_i));

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      store_q[wr_addr] <= sample_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= store_q[rd_addr];
  end

  // Voice state
  logic [VOICE_COUNT-1:0]     active_q;
  logic [svm_pkg::SND_W-1:0]  vsound_q [VOICE_COUNT];
  logic [LEN_W-1:0]           vpos_q   [VOICE_COUNT];
  logic [LEN_W-1:0]           vlen_q   [VOICE_COUNT];
  logic [GAIN_W-1:0]          vlgain_q [VOICE_COUNT];
  logic [GAIN_W-1:0]          vrgain_q [VOICE_COUNT];

  logic             trig_ok, hit;
  logic [VI_W-1:0]  trig_v;
  logic [LEN_W-1:0] len_sel, len_sat;

  // Capture the sound length, clipped to the region size
  assign trig_ok = cmd_i.trig_we && ({2'b0, voice_index_i} < VOICES_L) &&
                   ({1'b0, sound_index_i} < SOUNDS_L);
  assign trig_v  = VI_W'(voice_index_i);
  assign len_sel = len_cfg_q[sound_index_i[svm_pkg::SND_W-1:0]];
  assign len_sat = ({2'b0, len_sel} > SAMPLES_L) ? SAMPLES_L[LEN_W-1:0] : len_sel;

  // Visit the voice picked by the sequencer
  assign hit     = active_q[vidx_i] && (vpos_q[vidx_i] < vlen_q[vidx_i]);
  assign rd_addr = ADDR_W'(32'(vsound_q[vidx_i]) * 32'(SOUND_SAMPLES) + 32'(vpos_q[vidx_i]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (trig_ok) begin
      active_q[trig_v] <= 1'b1;
    end else if (cmd_i.issue && !hit) begin
      active_q[vidx_i] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (trig_ok) begin
      vsound_q[trig_v] <= sound_index_i[svm_pkg::SND_W-1:0];
      vpos_q[trig_v]   <= '0;
      vlen_q[trig_v]   <= len_sat;
      vlgain_q[trig_v] <= left_volume_i;
      vrgain_q[trig_v] <= right_volume_i;
    end else if (cmd_i.issue && hit) begin
      vpos_q[vidx_i] <= vpos_q[vidx_i] + LEN_W'(1);
    end
  end

  // Pipeline: read, multiply, accumulate
  logic                     s1_valid_q, p_valid_q;
  logic [GAIN_W-1:0]        s1_lgain_q, s1_rgain_q;
  logic signed [PROD_W-1:0] prod_l_q, prod_r_q, prod_l_d, prod_r_d;
  logic [SMP_W-1:0]         acc_l_q, acc_r_q, acc_l_d, acc_r_d;
  logic [SMP_W-1:0]         out_l_q, out_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      p_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.issue && hit;
      p_valid_q  <= s1_valid_q;
    end
  end

  assign prod_l_d = rdata_q * $signed({1'b0, s1_lgain_q});
  assign prod_r_d = rdata_q * $signed({1'b0, s1_rgain_q});

  // Floor by 2^8 is a bit-select; the sum wraps at 16 bits
  always_comb begin
    acc_l_d = acc_l_q;
    acc_r_d = acc_r_q;
    if (cmd_i.acc_clr) begin
      acc_l_d = '0;
      acc_r_d = '0;
    end else if (p_valid_q) begin
      acc_l_d = acc_l_q + prod_l_q[FRAC+SMP_W-1:FRAC];
      acc_r_d = acc_r_q + prod_r_q[FRAC+SMP_W-1:FRAC];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_lgain_q <= vlgain_q[vidx_i];
    s1_rgain_q <= vrgain_q[vidx_i];
    prod_l_q   <= prod_l_d;
    prod_r_q   <= prod_r_d;
    acc_l_q    <= acc_l_d;
    acc_r_q    <= acc_r_d;
    if (cmd_i.out_load) begin
      out_l_q <= acc_l_q;
      out_r_q <= acc_r_q;
    end
  end

  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;

endmodule

@@ src/sample_voice_mixer_unit.sv @@
// Four-voice stereo sample mixer: load, trigger and frame tick over a beat stream.
// Load and trigger beats are accepted while idle; a tick beat starts a frame that runs
// through MIX, DRAIN and FINISH; FINISH loads the frame once the output slot is free.
// The single store read port visits one voice per cycle, plus a three-stage
// read, multiply and accumulate pipeline. Reset clears voices and lengths;
// the sample store is not cleared and holds garbage until loaded.
module sample_voice_mixer_unit #(
  parameter int VOICE_COUNT   = 4,
  parameter int SOUND_COUNT   = 4,
  parameter int SOUND_SAMPLES = 16384
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // op, voice_index, sound_index, left_volume, right_volume,
  // sample_address, sample_value
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [$bits(svm_pkg::in_beat_t)-1:0]  s_axis_tdata,
  // left_out, right_out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [$bits(svm_pkg::out_beat_t)-1:0] m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [svm_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [svm_pkg::LEN_W-1:0]         cfg_data_i
);

  localparam int VI_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  svm_pkg::in_beat_t  in_beat;
  svm_pkg::out_beat_t out_beat;
  svm_pkg::ctrl_cmd_t cmd;
  logic [VI_W-1:0]    vidx;

  assign in_beat      = s_axis_tdata;
  assign m_axis_tdata = out_beat;

  svm_ctrl #(
    .VOICE_COUNT(VOICE_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (in_beat.op),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .vidx_o     (vidx)
  );

  svm_datapath #(
    .VOICE_COUNT  (VOICE_COUNT),
    .SOUND_COUNT  (SOUND_COUNT),
    .SOUND_SAMPLES(SOUND_SAMPLES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .vidx_i          (vidx),
    .voice_index_i   (in_beat.voice_index),
    .sound_index_i   (in_beat.sound_index),
    .left_volume_i   (in_beat.left_volume),
    .right_volume_i  (in_beat.right_volume),
    .sample_address_i(in_beat.sample_address),
    .sample_value_i  (in_beat.sample_value),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .left_out_o      (out_beat.left_out),
    .right_out_o     (out_beat.right_out)
  );

  // A tick beat makes the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && in_beat.op == svm_pkg::OP_TICK |=> !s_axis_tready)
    else $error("input taken right after a tick beat");

  // Voice reads never overlap with accepting beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.issue && s_axis_tready))
    else $error("voice issue while input ready");

  // Loading a frame always presents it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> m_axis_tvalid)
    else $error("frame loaded but not presented");

  // Accumulators clear only on an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.acc_clr |-> s_axis_tvalid && s_axis_tready)
    else $error("accumulator clear without a beat");

endmodule
